// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SLC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SLC_ASSERT(lbl, prop, msg)

`define SLC_ASSERT_NR(lbl, prop, msg)

`endif

`endif

// File: sv/slc_pkg.sv
package slc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int IN_W         = 24;
  localparam int NH_W         = 44;
  localparam int NK_W         = 49;
  localparam int Q_W          = 34;
  localparam int MANT_W       = 31;
  localparam int SH_W         = 6;
  localparam int EXP_W        = 7;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int PROD_W       = 65;
  localparam int VAL_W        = 17;
  localparam int CLS_W        = 3;
  localparam int CLS_SHIFT    = 14;
  localparam int SCALE_SHIFT  = 46;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [31:0] INV_PI_Q32 = 32'sd1367130551;

  typedef enum logic [1:0] {
    MODE_GAUSS = 2'd0,
    MODE_SHAPE = 2'd1,
    MODE_ACCUM = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_BASIN  = 3'd0,
    CLS_VALLEY = 3'd1,
    CLS_FLAT   = 3'd2,
    CLS_SADDLE = 3'd3,
    CLS_HILL   = 3'd4
  } cls_t;

  typedef struct packed {
    logic signed [IN_W-1:0] slope_x;
    logic signed [IN_W-1:0] slope_y;
    logic signed [IN_W-1:0] second_xx;
    logic signed [IN_W-1:0] second_yy;
    logic signed [IN_W-1:0] second_xy;
  } slc_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] landform_value;
    logic [CLS_W-1:0] landform_class;
  } slc_out_t;

  typedef struct packed {
    mode_t mode;
    cls_t  cls;
  } side_t;

  typedef struct packed {
    logic signed [NH_W-1:0] nh;
    logic signed [NK_W-1:0] nk;
    logic signed [Q_W-1:0]  q;
    side_t                  side;
  } curv_t;

  typedef struct packed {
    logic [RAD_W-1:0]         rad;
    logic signed [MANT_W-1:0] a;
    logic                     zero;
    side_t                    side;
  } prep_t;

  typedef struct packed {
    logic [ROOT_W-1:0]        b;
    logic signed [MANT_W-1:0] a;
    logic                     zero;
    side_t                    side;
  } root_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     zero;
    side_t                    side;
  } angle_t;

  // Arctangent of 2^-i in Q30 radians, rounded.
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] ret;
    ret = '0;
    case (i)
      0: ret = 33'sd843314857;
      1: ret = 33'sd497837829;
      2: ret = 33'sd263043837;
      3: ret = 33'sd133525159;
      4: ret = 33'sd67021687;
      5: ret = 33'sd33543516;
      6: ret = 33'sd16775851;
      7: ret = 33'sd8388437;
      8: ret = 33'sd4194283;
      9: ret = 33'sd2097149;
      default: ret[30-i] = 1'b1;
    endcase
    return ret;
  endfunction

endpackage

// File: sv/surface_landform_classifier_top.sv
// Landform classifier for one height-field pixel per transfer. The block is a
// 70-stage pipeline: 3 stages of curvature products and sign classes, 3 stages
// that normalize and form the radicand, 32 stages of a one-bit-per-stage
// square root, 30 CORDIC stages plus one scaling multiply, and the output
// register. It accepts one pixel every cycle while the output is not stalled;
// while a result waits at the output, the whole pipeline holds. The mode
// register is sampled as a pixel enters, so the user must write it only while
// no pixel is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module surface_landform_classifier_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slc_pkg::slc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output slc_pkg::slc_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);
  import slc_pkg::*;

  mode_t    mode_r;
  logic     adv;
  logic     cv_valid, pr_valid, rt_valid, cd_valid;
  curv_t    cv_data;
  prep_t    pr_data;
  root_t    rt_data;
  angle_t   cd_data;

  logic signed [PROD_W-1:0] rnd;
  logic signed [18:0]       ang;
  logic signed [19:0]       sv;
  logic [VAL_W-1:0]         shape_val;
  slc_out_t                 res_nxt;
  logic                     out_valid_r;
  slc_out_t                 out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GAUSS;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  slc_curv u_curv (
    .clk, .rst_n, .adv,
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mode      (mode_r),
    .out_valid (cv_valid),
    .out_data  (cv_data)
  );

  slc_prep u_prep (
    .clk, .rst_n, .adv,
    .in_valid  (cv_valid),
    .in_data   (cv_data),
    .out_valid (pr_valid),
    .out_data  (pr_data)
  );

  slc_sqrt u_sqrt (
    .clk, .rst_n, .adv,
    .in_valid  (pr_valid),
    .in_data   (pr_data),
    .out_valid (rt_valid),
    .out_data  (rt_data)
  );

  slc_cordic u_cordic (
    .clk, .rst_n, .adv,
    .in_valid  (rt_valid),
    .in_data   (rt_data),
    .out_valid (cd_valid),
    .out_data  (cd_data)
  );

  always_comb begin
    rnd = cd_data.prod + (65'sd1 <<< (SCALE_SHIFT - 1));
    ang = 19'(rnd >>> SCALE_SHIFT);
    sv  = 20'sd32768 + 20'(ang);
    if (cd_data.zero) shape_val = VAL_W'(32768);
    else if (sv < 0) shape_val = '0;
    else if (sv > 20'sd65536) shape_val = VAL_W'(65536);
    else shape_val = VAL_W'(sv);

    res_nxt.landform_class = cd_data.side.cls;
    case (cd_data.side.mode)
      MODE_SHAPE: res_nxt.landform_value = shape_val;
      default:    res_nxt.landform_value = {cd_data.side.cls, CLS_SHIFT'(0)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SLC_ASSERT(a_class_value, out_valid_r && out_data_r.landform_class != 0 |-> out_data_r.landform_value == {out_data_r.landform_class, 14'd0}, "class and value disagree")
  `SLC_ASSERT_NR(a_reset_empty, !rst_n |=> !out_valid_r && !cd_valid, "pipeline not empty after reset")
  `SLC_ASSERT(a_stall_hold, cd_valid && !adv |=> cd_valid && $stable(cd_data.prod), "pipeline moved during stall")

endmodule

// File: sv/slc_curv.sv
module slc_curv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  slc_pkg::slc_in_t in_data,
  input  slc_pkg::mode_t  mode,
  output logic            out_valid,
  output slc_pkg::curv_t  out_data
);
  import slc_pkg::*;

  function automatic cls_t gauss_cls(input logic signed [NK_W-1:0] k,
                                     input logic signed [NH_W-1:0] h);
    cls_t c;
    if (k > 0 && h > 0) c = CLS_HILL;
    else if (k < 0 && h > 0) c = CLS_SADDLE;
    else if (k == 0 || h == 0) c = CLS_FLAT;
    else if (k < 0 && h < 0) c = CLS_VALLEY;
    else c = CLS_BASIN;
    return c;
  endfunction

  function automatic cls_t accum_cls(input logic signed [NH_W-1:0] kh,
                                     input logic signed [NH_W-1:0] kv);
    cls_t c;
    if (kh > 0 && kv > 0) c = CLS_HILL;
    else if (kh > 0 && kv < 0) c = CLS_SADDLE;
    else if (kh == 0 || kv == 0) c = CLS_FLAT;
    else if (kh < 0 && kv > 0) c = CLS_VALLEY;
    else c = CLS_BASIN;
    return c;
  endfunction

  logic                 v1_r, v2_r, v3_r;
  slc_in_t              in1_r;
  mode_t                mode1_r, mode2_r;
  logic signed [47:0]   pxx_r, pyy_r, pxyx_r, pk1_r, pk2_r;

  logic signed [31:0]   zx2, zy2, txy;
  logic signed [32:0]   onep_x, onep_y, p_sum;
  logic signed [55:0]   xyp_r, h1_r, h2_r, w1_r, w2_r;
  logic signed [56:0]   m1_r, m2_r;
  logic signed [NK_W-1:0] nk_r;
  logic signed [32:0]   p_r;

  logic signed [39:0]   xy;
  logic signed [NH_W-1:0] nh_val, kh_val, kv_val;
  cls_t                 cls_sel;
  curv_t                curv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in1_r   <= in_data;
      mode1_r <= mode;
      pxx_r   <= in_data.slope_x * in_data.slope_x;
      pyy_r   <= in_data.slope_y * in_data.slope_y;
      pxyx_r  <= in_data.second_xy * in_data.slope_x;
      pk1_r   <= in_data.second_xx * in_data.second_yy;
      pk2_r   <= in_data.second_xy * in_data.second_xy;
    end
  end

  always_comb begin
    zx2    = 32'(pxx_r >>> FRAC_BITS);
    zy2    = 32'(pyy_r >>> FRAC_BITS);
    txy    = 32'(pxyx_r >>> FRAC_BITS);
    onep_x = 33'(ONE_L) + 33'(zx2);
    onep_y = 33'(ONE_L) + 33'(zy2);
    p_sum  = 33'(zx2) + 33'(zy2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2_r <= mode1_r;
      xyp_r   <= txy * in1_r.slope_y;
      m1_r    <= onep_y * in1_r.second_xx;
      m2_r    <= onep_x * in1_r.second_yy;
      h1_r    <= zy2 * in1_r.second_xx;
      h2_r    <= zx2 * in1_r.second_yy;
      w1_r    <= zx2 * in1_r.second_xx;
      w2_r    <= zy2 * in1_r.second_yy;
      nk_r    <= 49'(pk1_r) - 49'(pk2_r);
      p_r     <= p_sum;
    end
  end

  always_comb begin
    xy     = 40'(xyp_r >>> FRAC_BITS);
    nh_val = 44'(m1_r >>> FRAC_BITS) - (44'(xy) <<< 1) + 44'(m2_r >>> FRAC_BITS);
    kh_val = '0;
    kv_val = '0;
    if (p_r != 0) begin
      kh_val = 44'(h1_r >>> FRAC_BITS) - (44'(xy) <<< 1) + 44'(h2_r >>> FRAC_BITS);
      kv_val = 44'(w1_r >>> FRAC_BITS) + (44'(xy) <<< 1) + 44'(w2_r >>> FRAC_BITS);
    end
    case (mode2_r)
      MODE_GAUSS: cls_sel = gauss_cls(nk_r, nh_val);
      MODE_ACCUM: cls_sel = accum_cls(kh_val, kv_val);
      default:    cls_sel = CLS_BASIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      curv_r.nh        <= nh_val;
      curv_r.nk        <= nk_r;
      curv_r.q         <= 34'(ONE_L) + 34'(p_r);
      curv_r.side.mode <= mode2_r;
      curv_r.side.cls  <= cls_sel;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = curv_r;

endmodule

// File: sv/slc_prep.sv
module slc_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  slc_pkg::curv_t in_data,
  output logic           out_valid,
  output slc_pkg::prep_t out_data
);
  import slc_pkg::*;

  // Smallest right shift that brings a value into a 31-bit signed mantissa.
  function automatic logic [SH_W-1:0] norm_shift(input logic signed [63:0] m);
    logic [SH_W-1:0]    e;
    logic signed [63:0] hi;
    e = '0;
    for (int s = 33; s >= 0; s--) begin
      hi = m >>> (30 + s);
      if (hi == '0 || hi == '1) e = SH_W'(s);
    end
    return e;
  endfunction

  logic                     v4_r, v5_r, v6_r;
  logic [SH_W-1:0]          ea, ek, eq;
  logic signed [MANT_W-1:0] am_r, km_r, qm_r, am5_r;
  logic [SH_W-1:0]          ea_r, ek_r, eq_r;
  side_t                    side4_r, side5_r;

  logic [EXP_W-1:0]         exp_a, exp_c, exp_max, sa_raw, sc_raw, sa, sc;
  logic signed [61:0]       aa_r, kq_r;
  logic [EXP_W-1:0]         sa_r, sc_r;

  logic signed [63:0]       rad;
  prep_t                    prep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    ea = norm_shift(64'(in_data.nh));
    ek = norm_shift(64'(in_data.nk));
    eq = norm_shift(64'(in_data.q));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      am_r    <= MANT_W'(in_data.nh >>> ea);
      km_r    <= MANT_W'(in_data.nk >>> ek);
      qm_r    <= MANT_W'(in_data.q >>> eq);
      ea_r    <= ea;
      ek_r    <= ek;
      eq_r    <= eq;
      side4_r <= in_data.side;
    end
  end

  always_comb begin
    exp_a   = {ea_r, 1'b0} + EXP_W'(FRAC_BITS);
    exp_c   = EXP_W'(ek_r) + EXP_W'(eq_r) + EXP_W'(2);
    exp_max = (exp_a > exp_c) ? exp_a : exp_c;
    sa_raw  = exp_max - exp_a;
    sc_raw  = exp_max - exp_c;
    sa      = sa_raw[0] ? sa_raw + EXP_W'(1) : sa_raw;
    sc      = sa_raw[0] ? sc_raw + EXP_W'(1) : sc_raw;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aa_r    <= am_r * am_r;
      kq_r    <= km_r * qm_r;
      sa_r    <= sa;
      sc_r    <= sc;
      am5_r   <= am_r;
      side5_r <= side4_r;
    end
  end

  assign rad = 64'(aa_r >>> sa_r) - 64'(kq_r >>> sc_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r.rad  <= rad;
      prep_r.zero <= (rad <= 0);
      prep_r.a    <= am5_r >>> sa_r[EXP_W-1:1];
      prep_r.side <= side5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = prep_r;

endmodule

// File: sv/slc_sqrt.sv
module slc_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  slc_pkg::prep_t in_data,
  output logic           out_valid,
  output slc_pkg::root_t out_data
);
  import slc_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]         v;
    logic [RAD_W-1:0]         res;
    logic signed [MANT_W-1:0] a;
    logic                     zero;
    side_t                    side;
  } sq_t;

  logic vld_r  [SQRT_STEPS];
  sq_t  pipe_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    sq_t  cur, step_nxt;
    logic vin;

    if (i == 0) begin : g_first
      assign cur = '{v: in_data.rad, res: '0, a: in_data.a, zero: in_data.zero,
                     side: in_data.side};
      assign vin = in_valid;
    end else begin : g_next
      assign cur = pipe_r[i-1];
      assign vin = vld_r[i-1];
    end

    always_comb begin
      step_nxt = cur;
      if (cur.v >= cur.res + BIT) begin
        step_nxt.v   = cur.v - (cur.res + BIT);
        step_nxt.res = (cur.res >> 1) + BIT;
      end else begin
        step_nxt.res = cur.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[i] <= step_nxt;
      end
    end
  end

  assign out_valid     = vld_r[SQRT_STEPS-1];
  assign out_data.b    = pipe_r[SQRT_STEPS-1].res[ROOT_W-1:0];
  assign out_data.a    = pipe_r[SQRT_STEPS-1].a;
  assign out_data.zero = pipe_r[SQRT_STEPS-1].zero;
  assign out_data.side = pipe_r[SQRT_STEPS-1].side;

endmodule

// File: sv/slc_cordic.sv
module slc_cordic (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  slc_pkg::root_t  in_data,
  output logic            out_valid,
  output slc_pkg::angle_t out_data
);
  import slc_pkg::*;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    side_t                  side;
  } cd_t;

  logic   vld_r  [CORDIC_STEPS];
  cd_t    pipe_r [CORDIC_STEPS];
  logic   vs_r;
  angle_t ang_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] ANG = atan_q30(i);
    cd_t  cur, step_nxt;
    logic vin;

    if (i == 0) begin : g_first
      assign cur = '{x: XY_W'({1'b0, in_data.b}), y: XY_W'(in_data.a), z: '0,
                     zero: in_data.zero, side: in_data.side};
      assign vin = in_valid;
    end else begin : g_next
      assign cur = pipe_r[i-1];
      assign vin = vld_r[i-1];
    end

    always_comb begin
      step_nxt = cur;
      if (!cur.y[XY_W-1]) begin
        step_nxt.x = cur.x + (cur.y >>> i);
        step_nxt.y = cur.y - (cur.x >>> i);
        step_nxt.z = cur.z + ANG;
      end else begin
        step_nxt.x = cur.x - (cur.y >>> i);
        step_nxt.y = cur.y + (cur.x >>> i);
        step_nxt.z = cur.z - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[i] <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= vld_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r.prod <= pipe_r[CORDIC_STEPS-1].z * INV_PI_Q32;
      ang_r.zero <= pipe_r[CORDIC_STEPS-1].zero;
      ang_r.side <= pipe_r[CORDIC_STEPS-1].side;
    end
  end

  assign out_valid = vs_r;
  assign out_data  = ang_r;

endmodule
